@@ design/nfps_pkg.sv @@
// Shared types and constants for the nearest facet plane search block.
package nfps_pkg;

  localparam int MAX_FACETS = 1024;
  localparam int FACET_AW   = $clog2(MAX_FACETS);
  localparam int CNT_W      = FACET_AW + 1;
  localparam int NORM_W     = 16;
  localparam int OFS_W      = 48;
  localparam int ACC_W      = 64;
  localparam int OPD_W      = 33;
  localparam int TOL_W      = 31;
  localparam int LEN_W      = 31;
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(66);

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t               command;
    logic signed [31:0] point_a_x;
    logic signed [31:0] point_a_y;
    logic signed [31:0] point_a_z;
    logic signed [31:0] point_b_x;
    logic signed [31:0] point_b_y;
    logic signed [31:0] point_b_z;
    logic signed [31:0] point_c_x;
    logic signed [31:0] point_c_y;
    logic signed [31:0] point_c_z;
  } item_t;

  typedef struct packed {
    logic               found;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [9:0]         facet_index;
    logic [10:0]        facets_held;
    logic               dropped;
  } result_t;

  // One multiply-accumulate request
  typedef struct packed {
    logic                    valid;
    logic                    clear;
    logic                    neg;
    logic signed [OPD_W-1:0] a;
    logic signed [OPD_W-1:0] b;
  } mac_op_t;

  // Start request for the bit-serial root / divide unit
  typedef struct packed {
    logic start;
    logic sqrt_mode;
  } iter_req_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_EDGE,
    S_CROSS,
    S_NFIT,
    S_SQ,
    S_SQWAIT,
    S_DSTART,
    S_DWAIT,
    S_OFF,
    S_WRITE,
    S_SADDR,
    S_SX,
    S_SY,
    S_SZ,
    S_SW,
    S_SS,
    S_SCMP,
    S_DONE
  } state_t;

endpackage

@@ design/nfps_ram.sv @@
// Generic single-port RAM with registered read.
module nfps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ design/nfps_mac.sv @@
// Shared multiply-accumulate unit: registered product, then accumulate.
module nfps_mac
  import nfps_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  mac_op_t                 op,
  output logic signed [ACC_W-1:0] acc
);

  logic signed [2*OPD_W-1:0] prod_full;
  logic signed [ACC_W-1:0]   prod;
  logic                      p_valid;
  logic                      p_clear;
  logic                      p_neg;
  logic signed [ACC_W-1:0]   acc_base;

  assign prod_full = op.a * op.b;
  assign acc_base  = p_clear ? '0 : acc;

  // product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= op.valid;
    end
    p_clear <= op.clear;
    p_neg   <= op.neg;
    prod    <= prod_full[ACC_W-1:0];
  end

  // accumulate stage
  always_ff @(posedge clk) begin
    if (p_valid) begin
      acc <= p_neg ? acc_base - prod : acc_base + prod;
    end
  end

endmodule

@@ design/nfps_iter.sv @@
// Bit-serial unit: 64-bit integer square root or 15-bit quotient divide.
module nfps_iter
  import nfps_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  iter_req_t        req,
  input  logic [63:0]      x_in,
  input  logic [LEN_W-1:0] divisor,
  output logic             done,
  output logic [31:0]      res
);

  logic        busy;
  logic        sq;
  logic [63:0] x;
  logic [63:0] r;
  logic [63:0] bitv;
  logic [63:0] dv;
  logic [63:0] sub;
  logic        take;
  logic [63:0] bit_next;

  // one trial subtract per cycle while busy
  assign sub      = sq ? r + bitv : dv;
  assign take     = x >= sub;
  assign bit_next = sq ? bitv >> 2 : bitv >> 1;
  assign res      = r[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && bit_next == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      sq   <= req.sqrt_mode;
      x    <= x_in;
      r    <= '0;
      bitv <= req.sqrt_mode ? 64'd1 << 62 : 64'd1 << 14;
      dv   <= {18'd0, divisor, 15'd0};
    end else if (busy) begin
      if (take) begin
        x <= x - sub;
      end
      if (sq) begin
        r <= take ? (r >> 1) + bitv : r >> 1;
      end else begin
        r <= take ? r | bitv : r;
      end
      bitv <= bit_next;
      dv   <= dv >> 1;
    end
  end

endmodule

@@ design/nearest_facet_plane_search_core.sv @@
// Top level: sequencer, facet stores, shared MAC and root/divide unit.
// Clear, an unused command and a load into a full store go straight to the result. A load of
// a degenerate facet skips to the write; others scale the normal, take its root and run three
// divides. A query on an empty store goes straight to the result, else each facet is scored by
// three serial MAC multiplies (a zero plane is skipped once read). Items are taken one at a
// time, also while the last result waits. Synchronous reset empties the store, sets tolerance 66.
module nearest_facet_plane_search_core
  import nfps_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  item_t            item,
  output logic             result_valid,
  input  logic             result_stall,
  output result_t          result,
  input  logic             cfg_write,
  input  logic [TOL_W-1:0] cfg_data
);

  state_t state, state_next;

  // control state
  logic [CNT_W-1:0] count;
  logic [TOL_W-1:0] tol;

  // datapath registers
  item_t                   it;
  logic signed [30:0]      e [3];
  logic signed [30:0]      f [3];
  logic signed [32:0]      sm [3];
  logic [60:0]             nmag [3];
  logic [2:0]              nsgn;
  logic [LEN_W-1:0]        len;
  logic signed [NORM_W-1:0] q [3];
  logic signed [OFS_W-1:0] ofs;
  logic [CNT_W-1:0]        k;
  logic [1:0]              comp;
  logic [2:0]              step;
  logic signed [NORM_W-1:0] p [3];
  logic signed [OFS_W-1:0] d_reg;
  logic signed [ACC_W-1:0] s_reg;
  logic [ACC_W-1:0]        best;
  logic                    have;
  logic [FACET_AW-1:0]     bk;
  logic                    live;
  logic                    dropped_r;

  // unit interfaces
  mac_op_t                 mop;
  logic signed [ACC_W-1:0] acc;
  iter_req_t               ireq;
  logic [63:0]             ix;
  logic                    idone;
  logic [31:0]             ires;

  logic                    ram_we;
  logic [FACET_AW-1:0]     ram_addr;
  logic [3*NORM_W-1:0]     nrm_rd;
  logic [OFS_W-1:0]        ofs_rd;

  // helpers
  logic signed [31:0]      pa [3];
  logic signed [31:0]      pb [3];
  logic signed [31:0]      pc [3];
  logic signed [32:0]      ed [3];
  logic signed [32:0]      fd [3];
  logic [1:0]              esh;
  logic [1:0]              fsh;
  logic [ACC_W-1:0]        acc_mag;
  logic [ACC_W-1:0]        s_mag;
  logic [ACC_W-1:0]        limit;
  logic [CNT_W-1:0]        k_plus;
  logic                    nbig;
  logic signed [NORM_W-1:0] rd_n [3];
  logic                    accept;

  function automatic logic [32:0] mag33(logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  function automatic logic [1:0] fit_shift(logic signed [32:0] v0, logic signed [32:0] v1,
                                           logic signed [32:0] v2);
    logic [32:0] o;
    o = mag33(v0) | mag33(v1) | mag33(v2);
    if (o[32]) return 2'd3;
    else if (o[31]) return 2'd2;
    else if (o[30]) return 2'd1;
    else return 2'd0;
  endfunction

  // magnitude shift, truncating toward zero
  function automatic logic signed [30:0] shrink(logic signed [32:0] v, logic [1:0] sh);
    logic [32:0] m;
    m = mag33(v) >> sh;
    return v[32] ? 31'(-$signed(m[30:0])) : $signed(m[30:0]);
  endfunction

  assign pa[0] = it.point_a_x;
  assign pa[1] = it.point_a_y;
  assign pa[2] = it.point_a_z;
  assign pb[0] = it.point_b_x;
  assign pb[1] = it.point_b_y;
  assign pb[2] = it.point_b_z;
  assign pc[0] = it.point_c_x;
  assign pc[1] = it.point_c_y;
  assign pc[2] = it.point_c_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ed[i] = 33'(pc[i]) - 33'(pb[i]);
      fd[i] = 33'(pa[i]) - 33'(pb[i]);
    end
  end

  assign esh     = fit_shift(ed[0], ed[1], ed[2]);
  assign fsh     = fit_shift(fd[0], fd[1], fd[2]);
  assign acc_mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
  assign s_mag   = s_reg[ACC_W-1] ? ACC_W'(-s_reg) : ACC_W'(s_reg);
  assign limit   = {18'd0, tol, 15'd0};
  assign k_plus  = k + CNT_W'(1);
  assign nbig    = (nmag[0][60:30] != '0) || (nmag[1][60:30] != '0) ||
                   (nmag[2][60:30] != '0);
  assign rd_n[0] = $signed(nrm_rd[47:32]);
  assign rd_n[1] = $signed(nrm_rd[31:16]);
  assign rd_n[2] = $signed(nrm_rd[15:0]);
  assign accept  = item_valid && !item_stall;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (item.command == CMD_LOAD && count < CNT_W'(MAX_FACETS)) begin
            state_next = S_EDGE;
          end else if (item.command == CMD_QUERY) begin
            state_next = S_EDGE;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_EDGE: begin
        if (it.command == CMD_LOAD) state_next = S_CROSS;
        else if (count == '0) state_next = S_DONE;
        else state_next = S_SADDR;
      end
      S_CROSS: begin
        if (step == 3'd7) begin
          if (nmag[0] == '0 && nmag[1] == '0 && acc == '0) state_next = S_WRITE;
          else state_next = S_NFIT;
        end
      end
      S_NFIT:   if (!nbig) state_next = S_SQ;
      S_SQ:     if (step == 3'd4) state_next = S_SQWAIT;
      S_SQWAIT: if (idone) state_next = S_DSTART;
      S_DSTART: state_next = S_DWAIT;
      S_DWAIT: begin
        if (idone) state_next = (comp == 2'd2) ? S_OFF : S_DSTART;
      end
      S_OFF:    if (step == 3'd4) state_next = S_WRITE;
      S_WRITE:  state_next = S_DONE;
      S_SADDR:  state_next = S_SX;
      S_SX:     state_next = (rd_n[0] == '0 && rd_n[1] == '0 && rd_n[2] == '0) ? S_SCMP : S_SY;
      S_SY:     state_next = S_SZ;
      S_SZ:     state_next = S_SW;
      S_SW:     state_next = S_SS;
      S_SS:     state_next = S_SCMP;
      S_SCMP:   state_next = (k_plus == count) ? S_DONE : S_SX;
      S_DONE:   if (!result_valid || !result_stall) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // unit controls
  always_comb begin
    mop       = '0;
    ireq      = '0;
    ix        = '0;
    ram_we    = 1'b0;
    ram_addr  = k[FACET_AW-1:0];
    item_stall = (state != S_IDLE);
    case (state)
      S_CROSS: begin
        mop.valid = (step < 3'd6);
        mop.clear = ~step[0];
        mop.neg   = step[0];
        case (step)
          3'd0: begin mop.a = 33'(e[1]); mop.b = 33'(f[2]); end
          3'd1: begin mop.a = 33'(e[2]); mop.b = 33'(f[1]); end
          3'd2: begin mop.a = 33'(e[2]); mop.b = 33'(f[0]); end
          3'd3: begin mop.a = 33'(e[0]); mop.b = 33'(f[2]); end
          3'd4: begin mop.a = 33'(e[0]); mop.b = 33'(f[1]); end
          3'd5: begin mop.a = 33'(e[1]); mop.b = 33'(f[0]); end
          default: begin mop.a = '0; mop.b = '0; end
        endcase
      end
      S_SQ: begin
        if (step < 3'd3) begin
          mop.valid = 1'b1;
          mop.clear = (step == 3'd0);
          mop.a     = {3'd0, nmag[step[1:0]][29:0]};
          mop.b     = {3'd0, nmag[step[1:0]][29:0]};
        end
        if (step == 3'd4) begin
          ireq.start     = 1'b1;
          ireq.sqrt_mode = 1'b1;
          ix             = acc_mag;
        end
      end
      S_DSTART: begin
        ireq.start = 1'b1;
        ix = {19'd0, nmag[comp][29:0], 15'd0} + {33'd0, len};
      end
      S_OFF: begin
        if (step < 3'd3) begin
          mop.valid = 1'b1;
          mop.clear = (step == 3'd0);
          mop.neg   = 1'b1;
          mop.a     = 33'(pa[step[1:0]]);
          mop.b     = 33'(q[step[1:0]]);
        end
      end
      S_WRITE: begin
        ram_we   = 1'b1;
        ram_addr = count[FACET_AW-1:0];
      end
      S_SX: begin
        mop.valid = 1'b1;
        mop.clear = 1'b1;
        mop.a     = sm[0];
        mop.b     = 33'(rd_n[0]);
      end
      S_SY: begin
        mop.valid = 1'b1;
        mop.a     = sm[1];
        mop.b     = 33'(p[1]);
      end
      S_SZ: begin
        mop.valid = 1'b1;
        mop.a     = sm[2];
        mop.b     = 33'(p[2]);
      end
      S_SCMP:  ram_addr = k_plus[FACET_AW-1:0];
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      tol          <= TOL_RESET;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) tol <= cfg_data;
      if (accept && item.command == CMD_CLEAR) count <= '0;
      if (state == S_WRITE) count <= count + CNT_W'(1);
      if (state == S_DONE && (!result_valid || !result_stall)) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          it        <= item;
          have      <= 1'b0;
          dropped_r <= (item.command == CMD_LOAD) && (count >= CNT_W'(MAX_FACETS));
        end
      end
      S_EDGE: begin
        for (int i = 0; i < 3; i++) begin
          e[i]  <= shrink(ed[i], esh);
          f[i]  <= shrink(fd[i], fsh);
          sm[i] <= 33'(pa[i]) + 33'(pb[i]);
        end
        step <= '0;
        k    <= '0;
      end
      S_CROSS: begin
        step <= step + 3'd1;
        if (step == 3'd3 || step == 3'd5 || step == 3'd7) begin
          nmag[step[2:1] - 2'd1] <= acc_mag[60:0];
          nsgn[step[2:1] - 2'd1] <= acc[ACC_W-1];
        end
        for (int i = 0; i < 3; i++) q[i] <= '0;
        ofs <= '0;
      end
      S_NFIT: begin
        if (nbig) begin
          for (int i = 0; i < 3; i++) nmag[i] <= nmag[i] >> 1;
        end
        step <= '0;
      end
      S_SQ: step <= step + 3'd1;
      S_SQWAIT: begin
        if (idone) len <= ires[LEN_W-1:0];
        comp <= '0;
      end
      S_DWAIT: begin
        if (idone) begin
          q[comp] <= nsgn[comp] ? -$signed(ires[NORM_W-1:0]) : $signed(ires[NORM_W-1:0]);
          comp    <= comp + 2'd1;
        end
        step <= '0;
      end
      S_OFF: begin
        step <= step + 3'd1;
        if (step == 3'd4) ofs <= acc[OFS_W-1:0];
      end
      S_SX: begin
        live  <= !(rd_n[0] == '0 && rd_n[1] == '0 && rd_n[2] == '0);
        p[0]  <= rd_n[0];
        p[1]  <= rd_n[1];
        p[2]  <= rd_n[2];
        d_reg <= $signed(ofs_rd);
      end
      S_SS: s_reg <= acc + (ACC_W'(d_reg) <<< 1);
      S_SCMP: begin
        if (live && s_mag < limit && (!have || s_mag < best)) begin
          have <= 1'b1;
          best <= s_mag;
          bk   <= k[FACET_AW-1:0];
          q[0] <= p[0];
          q[1] <= p[1];
          q[2] <= p[2];
        end
        k <= k_plus;
      end
      default: ;
    endcase
  end

  // result beat
  always_ff @(posedge clk) begin
    if (state == S_DONE && (!result_valid || !result_stall)) begin
      result.found       <= (it.command == CMD_QUERY) && have;
      result.normal_x    <= ((it.command == CMD_QUERY) && have) ? q[0] : '0;
      result.normal_y    <= ((it.command == CMD_QUERY) && have) ? q[1] : '0;
      result.normal_z    <= ((it.command == CMD_QUERY) && have) ? q[2] : '0;
      result.facet_index <= ((it.command == CMD_QUERY) && have) ? bk : '0;
      result.facets_held <= count;
      result.dropped     <= dropped_r;
    end
  end

  nfps_mac u_mac (
    .clk (clk),
    .rst (rst),
    .op  (mop),
    .acc (acc)
  );

  nfps_iter u_iter (
    .clk     (clk),
    .rst     (rst),
    .req     (ireq),
    .x_in    (ix),
    .divisor (len),
    .done    (idone),
    .res     (ires)
  );

  nfps_ram #(.WIDTH(3*NORM_W), .DEPTH(MAX_FACETS)) u_normal_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata ({q[0], q[1], q[2]}),
    .rdata (nrm_rd)
  );

  nfps_ram #(.WIDTH(OFS_W), .DEPTH(MAX_FACETS)) u_offset_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ofs),
    .rdata (ofs_rd)
  );

endmodule

@@ design/nfps_checker.sv @@
// Port-level checks for the nearest facet plane search block, bound to the top.
module nfps_checker
  import nfps_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // a match names a facet that is held
  a_index: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.found |-> {1'b0, result.facet_index} < result.facets_held)
    else $error("matched index beyond store");

  // no match gives zero normal and index
  a_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.found |->
      result.normal_x == '0 && result.normal_y == '0 && result.normal_z == '0 &&
      result.facet_index == '0)
    else $error("nonzero plane without match");

  // a drop only happens on a full store
  a_drop: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.dropped |->
      result.facets_held == 11'(MAX_FACETS) && !result.found)
    else $error("drop with room left");

endmodule

bind nearest_facet_plane_search_core nfps_checker u_nfps_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

@@ sim/nearest_facet_plane_search_core_test.sv @@
// Testbench for the nearest facet plane search core: random and directed beats.
module nearest_facet_plane_search_core_test
  import nfps_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Scoreboard: plane store predictor plus queue of expected results
  class facet_scoreboard;
    shortint plane_normal[MAX_FACETS][3];
    longint plane_offset[MAX_FACETS];
    int held;
    longint unsigned tolerance;
    result_t pending[$];
    int fails;

    function new();
      held = 0;
      tolerance = 66;
      fails = 0;
    endfunction

    function longint unsigned mag(longint v);
      return v < 0 ? -v : v;
    endfunction

    // Truncate magnitudes until every component is below 2^30
    function void fit30(inout longint v[3]);
      longint unsigned mx;
      int sh;
      mx = 0;
      sh = 0;
      for (int i = 0; i < 3; i++) if (mag(v[i]) > mx) mx = mag(v[i]);
      while ((mx >> sh) >= (64'd1 << 30)) sh++;
      for (int i = 0; i < 3; i++) begin
        if (v[i] < 0) v[i] = -longint'(mag(v[i]) >> sh);
        else v[i] = longint'(mag(v[i]) >> sh);
      end
    endfunction

    function longint unsigned int_root(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function void store_plane(item_t it, int slot);
      longint a[3], b[3], c[3], e[3], f[3], n[3];
      shortint q[3];
      longint d;
      longint unsigned sq, len, r;
      a = '{it.point_a_x, it.point_a_y, it.point_a_z};
      b = '{it.point_b_x, it.point_b_y, it.point_b_z};
      c = '{it.point_c_x, it.point_c_y, it.point_c_z};
      for (int i = 0; i < 3; i++) begin
        e[i] = c[i] - b[i];
        f[i] = a[i] - b[i];
        q[i] = 0;
      end
      d = 0;
      fit30(e);
      fit30(f);
      n[0] = e[1] * f[2] - e[2] * f[1];
      n[1] = e[2] * f[0] - e[0] * f[2];
      n[2] = e[0] * f[1] - e[1] * f[0];
      if (n[0] != 0 || n[1] != 0 || n[2] != 0) begin
        fit30(n);
        sq = 0;
        for (int i = 0; i < 3; i++) sq += mag(n[i]) * mag(n[i]);
        len = int_root(sq);
        for (int i = 0; i < 3; i++) begin
          r = ((mag(n[i]) << 15) + len) / (len << 1);
          q[i] = n[i] < 0 ? -shortint'(r) : shortint'(r);
        end
        d = -(a[0] * q[0] + a[1] * q[1] + a[2] * q[2]);
      end
      for (int i = 0; i < 3; i++) plane_normal[slot][i] = q[i];
      plane_offset[slot] = d;
    endfunction

    // Predict the result of one accepted input beat
    function void note_item(item_t it);
      result_t res;
      longint sum[3];
      longint s;
      longint unsigned m, best, lim;
      bit have;
      res = '0;
      case (it.command)
        CMD_CLEAR: held = 0;
        CMD_LOAD: begin
          if (held >= MAX_FACETS) res.dropped = 1'b1;
          else begin
            store_plane(it, held);
            held++;
          end
        end
        CMD_QUERY: begin
          sum = '{longint'(it.point_a_x) + it.point_b_x, longint'(it.point_a_y) + it.point_b_y,
                  longint'(it.point_a_z) + it.point_b_z};
          lim = tolerance << 15;
          have = 0;
          best = 0;
          for (int k = 0; k < held; k++) begin
            if (plane_normal[k][0] == 0 && plane_normal[k][1] == 0 && plane_normal[k][2] == 0)
              continue;
            s = sum[0] * plane_normal[k][0] + sum[1] * plane_normal[k][1] +
                sum[2] * plane_normal[k][2] + 2 * plane_offset[k];
            m = mag(s);
            if (m < lim && (!have || m < best)) begin
              have = 1;
              best = m;
              res.found = 1'b1;
              res.facet_index = k[9:0];
              res.normal_x = plane_normal[k][0];
              res.normal_y = plane_normal[k][1];
              res.normal_z = plane_normal[k][2];
            end
          end
        end
        default: ;
      endcase
      res.facets_held = held[10:0];
      pending = {pending, res};
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected");
        fails++;
        return;
      end
      want = pending.pop_front();
      if (got.found !== want.found) begin
        $error("found exp %0d got %0d", want.found, got.found); fails++;
      end
      if (got.normal_x !== want.normal_x) begin
        $error("normal_x exp %0d got %0d", want.normal_x, got.normal_x); fails++;
      end
      if (got.normal_y !== want.normal_y) begin
        $error("normal_y exp %0d got %0d", want.normal_y, got.normal_y); fails++;
      end
      if (got.normal_z !== want.normal_z) begin
        $error("normal_z exp %0d got %0d", want.normal_z, got.normal_z); fails++;
      end
      if (got.facet_index !== want.facet_index) begin
        $error("facet_index exp %0d got %0d", want.facet_index, got.facet_index); fails++;
      end
      if (got.facets_held !== want.facets_held) begin
        $error("facets_held exp %0d got %0d", want.facets_held, got.facets_held); fails++;
      end
      if (got.dropped !== want.dropped) begin
        $error("dropped exp %0d got %0d", want.dropped, got.dropped); fails++;
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 40000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;
  logic cfg_write = 1'b0;
  logic [TOL_W-1:0] cfg_data = '0;

  facet_scoreboard sb = new();
  int idle_mode = 0;
  int quiet_cycles = 0;
  item_t loaded[$];

  nearest_facet_plane_search_core u_top (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_write(cfg_write), .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Result side: check accepted beats, stall at random
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result);
    case (idle_mode)
      0: result_stall <= ($urandom_range(0, 99) < 69);
      1: result_stall <= ($urandom_range(0, 99) < 11);
      default: result_stall <= 1'b0;
    endcase
  end

  // Watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Drive one input beat, with an optional random gap in front
  task automatic send_beat(item_t it);
    int pct;
    pct = idle_mode == 0 ? 11 : (idle_mode == 1 ? 69 : 0);
    if ($urandom_range(0, 99) < pct) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (item_stall);
    sb.note_item(it);
    if (it.command == CMD_CLEAR) loaded.delete();
    if (it.command == CMD_LOAD && loaded.size() < MAX_FACETS) loaded = {loaded, it};
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_tolerance(logic [TOL_W-1:0] v);
    drain();
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.tolerance = v;
  endtask

  function automatic logic signed [31:0] coord(bit wide);
    if (wide) return $urandom;
    return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
  endfunction

  function automatic item_t make_facet(bit wide);
    item_t it;
    it.command = CMD_LOAD;
    it.point_a_x = coord(wide); it.point_a_y = coord(wide); it.point_a_z = coord(wide);
    it.point_b_x = coord(wide); it.point_b_y = coord(wide); it.point_b_z = coord(wide);
    it.point_c_x = coord(wide); it.point_c_y = coord(wide); it.point_c_z = coord(wide);
    return it;
  endfunction

  // Segment whose midpoint lies near the plane of a stored facet, else a random one
  function automatic item_t make_query();
    item_t it, f;
    logic signed [31:0] p[3][3];
    int i, j;
    it = make_facet(1);
    it.command = CMD_QUERY;
    if (loaded.size() == 0 || $urandom_range(0, 4) == 0) return it;
    f = loaded[$urandom_range(0, loaded.size() - 1)];
    p[0] = '{f.point_a_x, f.point_a_y, f.point_a_z};
    p[1] = '{f.point_b_x, f.point_b_y, f.point_b_z};
    p[2] = '{f.point_c_x, f.point_c_y, f.point_c_z};
    i = $urandom_range(0, 2);
    j = (i + $urandom_range(1, 2)) % 3;
    it.point_a_x = p[i][0] + $signed($urandom_range(0, 64)) - 32;
    it.point_a_y = p[i][1];
    it.point_a_z = p[i][2];
    it.point_b_x = p[j][0];
    it.point_b_y = p[j][1] + $signed($urandom_range(0, 64)) - 32;
    it.point_b_z = p[j][2];
    return it;
  endfunction

  initial begin
    item_t it;
    int r;
    logic [TOL_W-1:0] tol_steps[5];
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty query, extremes, degenerate facets, unused command
    it = make_query(); send_beat(it);
    it = '0; it.command = CMD_LOAD;
    it.point_a_x = 32'h7FFFFFFF; it.point_a_y = 32'h80000000; it.point_a_z = 32'h7FFFFFFF;
    it.point_b_x = 32'h80000000; it.point_b_y = 32'h7FFFFFFF; it.point_b_z = 32'h80000000;
    it.point_c_x = 32'h7FFFFFFF; it.point_c_y = 32'h7FFFFFFF; it.point_c_z = 32'h80000000;
    send_beat(it);
    it.point_a_x = 32'hFFFFFFFF; it.point_b_y = 32'hFFFFFFFF; it.point_c_z = 32'h00000000;
    send_beat(it);
    it = '0; it.command = CMD_LOAD; send_beat(it);
    it.point_b_x = 32'h10000; it.point_c_x = 32'h20000; send_beat(it);
    it = '0; it.command = CMD_LOAD;
    it.point_a_x = 32'h10000; it.point_c_y = 32'h10000; send_beat(it);
    it = '0; it.command = CMD_QUERY; send_beat(it);
    it.point_a_z = 32'h20; it.point_b_z = -32'sh20; send_beat(it);
    it = make_facet(1); it.command = CMD_NONE; send_beat(it);
    it = make_facet(0); send_beat(it);
    it = make_query(); send_beat(it);
    it = make_query(); send_beat(it);
    it = '0; it.command = CMD_CLEAR; send_beat(it);
    it = make_query(); send_beat(it);

    // Zero and widest tolerance on a small store
    set_tolerance('0);
    it = make_facet(0); send_beat(it);
    it = make_query(); send_beat(it);
    set_tolerance('1);
    it = make_query(); send_beat(it);
    it = make_facet(1); it.command = CMD_QUERY; send_beat(it);

    // Fill the store, then a dropped load and one full scan
    idle_mode = 2;
    set_tolerance(TOL_RESET);
    while (sb.held < MAX_FACETS) begin
      it = make_facet($urandom_range(0, 9) == 0);
      send_beat(it);
    end
    it = make_facet(1); send_beat(it);
    it = make_query(); send_beat(it);
    it = '0; it.command = CMD_CLEAR; send_beat(it);

    // Random phases across idle modes and tolerance settings
    tol_steps = '{TOL_RESET, 31'h7FFFFFFF, 31'd1, 31'd4000, 31'd0};
    for (int n = 0; n < 400; n++) begin
      if (n % 80 == 0) begin
        idle_mode = n < 140 ? 0 : (n < 280 ? 1 : 2);
        set_tolerance(n == 240 ? TOL_W'($urandom_range(0, 31'h7FFFFFFF)) : tol_steps[n / 80]);
      end
      r = $urandom_range(0, 99);
      if (r < 4 || loaded.size() > 40) begin
        it = make_facet(1); it.command = CMD_CLEAR;
      end else if (r < 40) begin
        it = make_facet($urandom_range(0, 9) == 0);
        if ($urandom_range(0, 19) == 0) begin
          it.point_c_x = it.point_a_x; it.point_c_y = it.point_a_y;
          it.point_c_z = it.point_a_z;
        end
      end else if (r < 92) begin
        it = make_query();
      end else begin
        it = make_facet(1); it.command = CMD_NONE;
      end
      send_beat(it);
    end

    idle_mode = 2;
    drain();
    repeat (50) @(posedge clk);
    if (sb.fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
